@@ src/slsw_pkg.sv @@
// slsw_pkg: shared constants for the safety link sequence watchdog.
// Used by slsw_mod_serial and safety_link_sequence_watchdog; no dependencies.
package slsw_pkg;

    localparam int COUNT_BITS_DEF = 32;   // default sequence counter width
    localparam int MOD_W          = 32;   // modulus / limit / time / tally width
    localparam int REQ_W          = 2;
    localparam int MODE_W         = 2;
    localparam int FAULT_W        = 2;
    localparam int CFG_IDX_W      = 1;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_FRAME  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POLL   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESET  = 2'd2;

    // link states
    localparam logic [MODE_W-1:0] MODE_INIT     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUNNING  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FAILSAFE = 2'd2;

    // latched fault codes
    localparam logic [FAULT_W-1:0] FAULT_NONE      = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_SIGNATURE = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_COUNTER   = 2'd2;
    localparam logic [FAULT_W-1:0] FAULT_TIMEOUT   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 1'd1;

endpackage

@@ src/safety_link_sequence_watchdog.sv @@
// safety_link_sequence_watchdog: top level of the safety link receiver monitor.
// Depends on slsw_pkg and slsw_mod_serial.
//
// Receiver-side monitor for a safety layer carried over an untrusted channel. Each input
// item is a frame, a poll or a connection reset; each item yields exactly one result item
// with the pass flag, the link state (INIT, RUNNING, FAILSAFE), the latched fault and the
// accepted / rejected frame tallies. Polls, unused kinds, frames seen in FAILSAFE and frames
// with a bad signature are settled at the accepting edge; their result item is valid the
// next cycle when the result register is free. For a frame that reaches the sequence check and
// for a reset item, the incoming counter (or restart value) and the expected counter plus one
// are each reduced by the modulus in a bit-serial remainder unit, DW = max(COUNT_BITS, 32)
// bits wide, that consumes one dividend bit per cycle. The two units run side by side. One
// item is in work at a time and the next is taken the cycle after its result is registered.
// The result register holds a finished result while the next item is in work; the input
// stalls while an item is in work, and also when a second result is finished and the first
// one still waits for out_ready.
// Configuration writes (index 0 modulus, index 1 watchdog limit) are always ready and are
// only to be issued while the block is idle.
module safety_link_sequence_watchdog
    import slsw_pkg::*;
#(
    parameter int COUNT_BITS = slsw_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [slsw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [slsw_pkg::MOD_W-1:0]     cfg_data,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [slsw_pkg::REQ_W-1:0]     req_type,
    input  logic                           signature_good,
    input  logic [31:0]                    frame_counter,
    input  logic [31:0]                    now_ms,
    input  logic [31:0]                    restart_counter,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           item_ok,
    output logic [slsw_pkg::MODE_W-1:0]    link_state,
    output logic [slsw_pkg::FAULT_W-1:0]   fault_code,
    output logic [31:0]                    accepted_total,
    output logic [31:0]                    rejected_total
);

    // dividend width: counter field or the full counter register, whichever is wider
    localparam int DW = (COUNT_BITS > MOD_W) ? COUNT_BITS : MOD_W;
    localparam logic [DW:0]   ONE_SHIFT = (DW + 1)'(1) << COUNT_BITS;
    localparam logic [DW-1:0] CNT_MASK  = DW'(ONE_SHIFT - (DW + 1)'(1));

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE,
        ST_HOLD
    } state_t;

    // configuration
    logic [MOD_W-1:0] modulus_reg;
    logic [MOD_W-1:0] limit_reg;

    // control and architectural state
    state_t              state_reg,    state_next;
    logic                out_valid_reg, out_valid_next;
    logic                ok_reg,       ok_next;
    logic                is_reset_reg, is_reset_next;   // item in work is a reset
    logic [MODE_W-1:0]   mode_reg,     mode_next;
    logic [FAULT_W-1:0]  fault_reg,    fault_next;
    logic [COUNT_BITS-1:0] expected_reg, expected_next;
    logic [MOD_W-1:0]    last_time_reg, last_time_next;
    logic [MOD_W-1:0]    now_reg,      now_next;
    logic [MOD_W-1:0]    accept_reg,   accept_next;
    logic [MOD_W-1:0]    reject_reg,   reject_next;

    // result register
    logic                res_ok_reg,     res_ok_next;
    logic [MODE_W-1:0]   res_mode_reg,   res_mode_next;
    logic [FAULT_W-1:0]  res_fault_reg,  res_fault_next;
    logic [MOD_W-1:0]    res_accept_reg, res_accept_next;
    logic [MOD_W-1:0]    res_reject_reg, res_reject_next;

    logic                in_fire;
    logic                out_free;
    logic                publish;
    logic                start_div;
    logic [DW-1:0]       dividend_a;
    logic [DW-1:0]       dividend_b;
    logic [DW-1:0]       count_a_masked;
    logic [DW-1:0]       count_b_masked;
    logic                done_a;
    logic                done_b;
    logic [MOD_W-1:0]    rem_a;
    logic [MOD_W-1:0]    rem_b;
    logic [DW-1:0]       reduced_a;
    logic [DW-1:0]       reduced_b;
    logic [MOD_W-1:0]    elapsed;
    logic                needs_div;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= '0;
            limit_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODULUS: modulus_reg <= cfg_data;
                CFG_LIMIT:   limit_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    // result slot is free now or frees at this edge
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    // frames heading for the sequence check and reset items need the remainder units
    assign needs_div = ((req_type == REQ_FRAME) && (mode_reg != MODE_FAILSAFE) && signature_good)
                     || (req_type == REQ_RESET);
    assign start_div = in_fire && needs_div;

    // unit A: incoming counter (frame) or restart value (reset); unit B: expected + 1
    always_comb
    begin
        if (req_type == REQ_RESET)
            dividend_a = DW'(restart_counter) & CNT_MASK;
        else
            dividend_a = DW'(frame_counter) & CNT_MASK;
        dividend_b = (DW'(expected_reg) + DW'(1)) & CNT_MASK;
    end

    slsw_mod_serial #(
        .DATA_W (DW)
    ) u_mod_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_div),
        .dividend  (dividend_a),
        .modulus   (modulus_reg),
        .done      (done_a),
        .remainder (rem_a)
    );

    slsw_mod_serial #(
        .DATA_W (DW)
    ) u_mod_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_div),
        .dividend  (dividend_b),
        .modulus   (modulus_reg),
        .done      (done_b),
        .remainder (rem_b)
    );

    // masked dividends are held for the DONE step; modulus zero means plain wrap
    always_ff @(posedge clk)
    begin
        if (start_div)
        begin
            count_a_masked <= dividend_a;
            count_b_masked <= dividend_b;
        end
    end

    assign reduced_a = (modulus_reg == '0) ? count_a_masked : DW'(rem_a);
    assign reduced_b = (modulus_reg == '0) ? count_b_masked : DW'(rem_b);

    assign elapsed = now_ms - last_time_reg;

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        ok_next         = ok_reg;
        is_reset_next   = is_reset_reg;
        mode_next       = mode_reg;
        fault_next      = fault_reg;
        expected_next   = expected_reg;
        last_time_next  = last_time_reg;
        now_next        = now_reg;
        accept_next     = accept_reg;
        reject_next     = reject_reg;
        res_ok_next     = res_ok_reg;
        res_mode_next   = res_mode_reg;
        res_fault_next  = res_fault_reg;
        res_accept_next = res_accept_reg;
        res_reject_next = res_reject_reg;
        publish         = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    now_next      = now_ms;
                    is_reset_next = (req_type == REQ_RESET);
                    if (needs_div)
                    begin
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        // immediate items: settled at once, result out when the slot frees
                        ok_next = 1'b0;
                        case (req_type)
                            REQ_FRAME:
                            begin
                                reject_next = reject_reg + MOD_W'(1);
                                if (mode_reg != MODE_FAILSAFE)
                                begin
                                    mode_next  = MODE_FAILSAFE;
                                    fault_next = FAULT_SIGNATURE;
                                end
                            end
                            REQ_POLL:
                            begin
                                if (mode_reg != MODE_FAILSAFE)
                                begin
                                    if ((mode_reg == MODE_RUNNING) && (limit_reg != '0)
                                        && (elapsed >= limit_reg))
                                    begin
                                        mode_next  = MODE_FAILSAFE;
                                        fault_next = FAULT_TIMEOUT;
                                    end
                                    else
                                    begin
                                        ok_next = 1'b1;
                                    end
                                end
                            end
                            default: ;  // unused kind: report state only
                        endcase
                        if (out_free)
                            publish = 1'b1;
                        else
                            state_next = ST_HOLD;
                    end
                end
            end

            ST_RUN:
            begin
                if (done_a && done_b)
                    state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (is_reset_reg)
                begin
                    mode_next      = MODE_INIT;
                    fault_next     = FAULT_NONE;
                    expected_next  = COUNT_BITS'(reduced_a);
                    last_time_next = now_reg;
                    ok_next        = 1'b1;
                end
                else if (reduced_a == DW'(expected_reg))
                begin
                    expected_next  = COUNT_BITS'(reduced_b);
                    last_time_next = now_reg;
                    accept_next    = accept_reg + MOD_W'(1);
                    mode_next      = MODE_RUNNING;
                    ok_next        = 1'b1;
                end
                else
                begin
                    // link is not failsafe here, so this fault latches
                    reject_next = reject_reg + MOD_W'(1);
                    mode_next   = MODE_FAILSAFE;
                    fault_next  = FAULT_COUNTER;
                    ok_next     = 1'b0;
                end
                if (out_free)
                begin
                    publish    = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end

            ST_HOLD:
            begin
                // state already updated, waiting for the result slot
                if (out_free)
                begin
                    publish    = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // snapshot of the state after the item goes to the result register
        if (publish)
        begin
            out_valid_next  = 1'b1;
            res_ok_next     = ok_next;
            res_mode_next   = mode_next;
            res_fault_next  = fault_next;
            res_accept_next = accept_next;
            res_reject_next = reject_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            ok_reg         <= 1'b0;
            is_reset_reg   <= 1'b0;
            mode_reg       <= MODE_INIT;
            fault_reg      <= FAULT_NONE;
            expected_reg   <= '0;
            last_time_reg  <= '0;
            now_reg        <= '0;
            accept_reg     <= '0;
            reject_reg     <= '0;
            res_ok_reg     <= 1'b0;
            res_mode_reg   <= MODE_INIT;
            res_fault_reg  <= FAULT_NONE;
            res_accept_reg <= '0;
            res_reject_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            ok_reg         <= ok_next;
            is_reset_reg   <= is_reset_next;
            mode_reg       <= mode_next;
            fault_reg      <= fault_next;
            expected_reg   <= expected_next;
            last_time_reg  <= last_time_next;
            now_reg        <= now_next;
            accept_reg     <= accept_next;
            reject_reg     <= reject_next;
            res_ok_reg     <= res_ok_next;
            res_mode_reg   <= res_mode_next;
            res_fault_reg  <= res_fault_next;
            res_accept_reg <= res_accept_next;
            res_reject_reg <= res_reject_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign item_ok        = res_ok_reg;
    assign link_state     = res_mode_reg;
    assign fault_code     = res_fault_reg;
    assign accepted_total = res_accept_reg;
    assign rejected_total = res_reject_reg;

endmodule

@@ src/slsw_mod_serial.sv @@
// slsw_mod_serial: bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on slsw_pkg (MOD_W).
module slsw_mod_serial #(
    parameter int DATA_W = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DATA_W-1:0]        dividend,
    input  logic [slsw_pkg::MOD_W-1:0] modulus,
    output logic                     done,
    output logic [slsw_pkg::MOD_W-1:0] remainder
);
    import slsw_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DATA_W-1:0]  div_reg;
    logic [MOD_W-1:0]   rem_reg;

    logic [MOD_W:0]     trial;
    logic [MOD_W:0]     mod_ext;
    logic [MOD_W:0]     diff;
    logic [MOD_W-1:0]   rem_next;

    // shift in the next dividend bit, subtract when the partial remainder fits
    assign trial    = {rem_reg, div_reg[DATA_W-1]};
    assign mod_ext  = {1'b0, modulus};
    assign diff     = trial - mod_ext;
    assign rem_next = (trial >= mod_ext) ? diff[MOD_W-1:0] : trial[MOD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DATA_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            div_reg <= div_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// testbench: self-checking bench for safety_link_sequence_watchdog.
// Depends on slsw_pkg and the RTL under src/; predicts each status item
// and checks it against the block's result channel.
module testbench;
    import slsw_pkg::*;

    // kind code the block must ignore
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int LONG_HOLD   = 300;   // cycles of receiver back-pressure
    localparam int STALL_LIMIT = 3000;  // cycles without any handshake
    localparam int PHASE_ITEMS = 108;   // least number of random items per configuration

    typedef struct packed {
        logic [REQ_W-1:0] kind;
        logic             sig;
        logic [31:0]      fcount;
        logic [31:0]      now;
        logic [31:0]      restart;
    } link_req_t;

    typedef struct packed {
        logic               ok;
        logic [MODE_W-1:0]  mode;
        logic [FAULT_W-1:0] fault;
        logic [31:0]        accepts;
        logic [31:0]        rejects;
    } link_status_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [MOD_W-1:0]     value;
    } reg_write_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // block ports, all known from time zero
    logic                 cfg_valid       = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    logic [MOD_W-1:0]     cfg_data        = '0;
    logic                 in_valid        = 1'b0;
    logic                 in_ready;
    logic [REQ_W-1:0]     req_type        = '0;
    logic                 signature_good  = 1'b0;
    logic [31:0]          frame_counter   = '0;
    logic [31:0]          now_ms          = '0;
    logic [31:0]          restart_counter = '0;
    logic                 out_valid;
    logic                 out_ready       = 1'b0;
    logic                 item_ok;
    logic [MODE_W-1:0]    link_state;
    logic [FAULT_W-1:0]   fault_code;
    logic [31:0]          accepted_total;
    logic [31:0]          rejected_total;

    safety_link_sequence_watchdog i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .signature_good  (signature_good),
        .frame_counter   (frame_counter),
        .now_ms          (now_ms),
        .restart_counter (restart_counter),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .item_ok         (item_ok),
        .link_state      (link_state),
        .fault_code      (fault_code),
        .accepted_total  (accepted_total),
        .rejected_total  (rejected_total)
    );

    // stimulus queues and the store of predicted status items
    link_req_t    request_queue[$];
    reg_write_t   reg_write_queue[$];
    link_status_t status_queue[$];

    int unsigned items_pushed    = 0;
    int unsigned results_checked = 0;
    int unsigned writes_issued   = 0;
    int unsigned writes_done     = 0;
    int unsigned mismatches      = 0;

    // idling control, set per phase by the stimulus process
    logic sender_gaps_on   = 1'b1;
    logic receiver_gaps_on = 1'b1;
    logic want_long_hold   = 1'b0;
    logic long_hold_done   = 1'b0;

    // -------------------------------------------------------------------------
    // Link model: shadow of the registers and of the link state.
    // Register shadows follow config handshakes; link state follows
    // accepted request items.
    // -------------------------------------------------------------------------
    logic [31:0]        modulus_reg  = '0;
    logic [31:0]        limit_reg    = '0;
    logic [MODE_W-1:0]  link_mode    = MODE_INIT;
    logic [FAULT_W-1:0] link_fault   = FAULT_NONE;
    logic [31:0]        seq_expect   = '0;
    logic [31:0]        good_stamp   = '0;
    logic [31:0]        accept_count = '0;
    logic [31:0]        reject_count = '0;

    // counter reduction; zero modulus leaves the value as is (wrap at 2^32)
    function automatic logic [31:0] fold_with(logic [31:0] v, logic [31:0] m);
        return (m != 0) ? (v % m) : v;
    endfunction

    // the first fault latches, later ones leave it alone
    function automatic void trip(logic [FAULT_W-1:0] why);
        if (link_mode != MODE_FAILSAFE)
        begin
            link_mode  = MODE_FAILSAFE;
            link_fault = why;
        end
    endfunction

    // applies one request item to the model and returns the status it yields
    function automatic link_status_t link_update(link_req_t rq);
        link_status_t st;
        logic [31:0]  elapsed;
        st.ok = 1'b0;
        case (rq.kind)
            REQ_FRAME:
            begin
                if (link_mode == MODE_FAILSAFE)
                    reject_count = reject_count + 1;
                else if (!rq.sig)
                begin
                    // signature is judged before the counter
                    reject_count = reject_count + 1;
                    trip(FAULT_SIGNATURE);
                end
                else if (fold_with(rq.fcount, modulus_reg) != seq_expect)
                begin
                    reject_count = reject_count + 1;
                    trip(FAULT_COUNTER);
                end
                else
                begin
                    seq_expect   = fold_with(seq_expect + 32'd1, modulus_reg);
                    good_stamp   = rq.now;
                    accept_count = accept_count + 1;
                    link_mode    = MODE_RUNNING;
                    st.ok        = 1'b1;
                end
            end
            REQ_POLL:
            begin
                if (link_mode != MODE_FAILSAFE)
                begin
                    elapsed = rq.now - good_stamp;   // wraps mod 2^32
                    if (link_mode == MODE_RUNNING && limit_reg != 0 && elapsed >= limit_reg)
                        trip(FAULT_TIMEOUT);
                    else
                        st.ok = 1'b1;
                end
            end
            REQ_RESET:
            begin
                // tallies survive a connection reset
                link_mode  = MODE_INIT;
                link_fault = FAULT_NONE;
                seq_expect = fold_with(rq.restart, modulus_reg);
                good_stamp = rq.now;
                st.ok      = 1'b1;
            end
            default: ;   // unused kind: report only
        endcase
        st.mode    = link_mode;
        st.fault   = link_fault;
        st.accepts = accept_count;
        st.rejects = reject_count;
        return st;
    endfunction

    // gap lengths: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // -------------------------------------------------------------------------
    // Config write driver
    // -------------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_regs
        reg_write_t wr;
        if (!rst_n)
            cfg_valid <= 1'b0;
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MODULUS: modulus_reg = cfg_data;
                    CFG_LIMIT:   limit_reg   = cfg_data;
                    default: ;
                endcase
                writes_done++;
            end
            if (cfg_valid && !cfg_ready)
                ;   // hold the write until taken
            else if (reg_write_queue.size() != 0)
            begin
                wr = reg_write_queue.pop_front();
                cfg_index <= wr.index;
                cfg_data  <= wr.value;
                cfg_valid <= 1'b1;
            end
            else
                cfg_valid <= 1'b0;
        end
    end

    // -------------------------------------------------------------------------
    // Request driver: presents queued items, predicts on acceptance.
    // A gap drawn when an item is presented is spent after it is taken.
    // -------------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_requests
        link_req_t   cur_req;
        int unsigned send_gap;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                status_queue.push_back(link_update(cur_req));
            if (in_valid && !in_ready)
                ;   // keep offering the same item
            else if (send_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap = send_gap - 1;
            end
            else if (request_queue.size() != 0)
            begin
                cur_req = request_queue.pop_front();
                req_type        <= cur_req.kind;
                signature_good  <= cur_req.sig;
                frame_counter   <= cur_req.fcount;
                now_ms          <= cur_req.now;
                restart_counter <= cur_req.restart;
                in_valid        <= 1'b1;
                send_gap = sender_gaps_on ? pick_gap() : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // -------------------------------------------------------------------------
    // Result side back-pressure. The long hold is counted here, on request
    // from the stimulus process, and reported back through long_hold_done.
    // -------------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_ready
        int unsigned hold_count;
        int unsigned recv_gap;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_count = 0;
            recv_gap   = 0;
        end
        else if (want_long_hold && !long_hold_done)
        begin
            out_ready <= 1'b0;
            if (hold_count == LONG_HOLD)
                long_hold_done <= 1'b1;
            else
                hold_count = hold_count + 1;
        end
        else
        begin
            if (!want_long_hold)
            begin
                long_hold_done <= 1'b0;
                hold_count = 0;
            end
            if (recv_gap != 0)
            begin
                out_ready <= 1'b0;
                recv_gap = recv_gap - 1;
            end
            else if (receiver_gaps_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                recv_gap = pick_gap();
            end
            else
                out_ready <= 1'b1;
        end
    end

    // -------------------------------------------------------------------------
    // Result monitor: every taken status item against the oldest prediction
    // -------------------------------------------------------------------------
    task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        if (mismatches < 10)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_status
        link_status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (status_queue.size() == 0)
                flag_mismatch("unexpected item, accepted_total", 32'd0, accepted_total);
            else
            begin
                want = status_queue.pop_front();
                if (item_ok !== want.ok)
                    flag_mismatch("item_ok", 32'(want.ok), 32'(item_ok));
                if (link_state !== want.mode)
                    flag_mismatch("link_state", 32'(want.mode), 32'(link_state));
                if (fault_code !== want.fault)
                    flag_mismatch("fault_code", 32'(want.fault), 32'(fault_code));
                if (accepted_total !== want.accepts)
                    flag_mismatch("accepted_total", want.accepts, accepted_total);
                if (rejected_total !== want.rejects)
                    flag_mismatch("rejected_total", want.rejects, rejected_total);
            end
        end
    end

    // -------------------------------------------------------------------------
    // Watchdog: any handshake restarts the count
    // -------------------------------------------------------------------------
    always @(posedge clk)
    begin : stall_watch
        int unsigned idle_cycles;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT)
            begin
                $display("safety_link_sequence_watchdog verification failed");
                $finish;
            end
        end
    end

    // -------------------------------------------------------------------------
    // Stimulus
    // -------------------------------------------------------------------------
    // register values as last written, for the generator
    logic [31:0] phase_modulus = '0;
    logic [31:0] phase_limit   = '0;
    // generator's view of a clean sequence
    logic [31:0] gen_expect;
    logic [31:0] gen_stamp;
    logic        gen_running;

    task automatic push_req(logic [REQ_W-1:0] kind, logic sig, logic [31:0] fcount,
                            logic [31:0] now, logic [31:0] restart);
        link_req_t rq;
        rq.kind    = kind;
        rq.sig     = sig;
        rq.fcount  = fcount;
        rq.now     = now;
        rq.restart = restart;
        request_queue.push_back(rq);
        items_pushed++;
    endtask

    // the sender holds back until every prediction has been checked
    task automatic wait_results();
        while (results_checked < items_pushed)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [31:0] value);
        reg_write_t wr;
        wr.index = index;
        wr.value = value;
        reg_write_queue.push_back(wr);
        writes_issued++;
        while (writes_done < writes_issued)
            @(posedge clk);
        if (index == CFG_MODULUS)
            phase_modulus = value;
        else
            phase_limit = value;
    endtask

    task automatic set_regs(logic [31:0] modulus, logic [31:0] limit);
        write_reg(CFG_MODULUS, modulus);
        write_reg(CFG_LIMIT, limit);
    endtask

    // time step that stays inside the watchdog window
    function automatic logic [31:0] safe_delta();
        return (phase_limit == 0) ? $urandom : $urandom_range(0, phase_limit - 1);
    endfunction

    function automatic logic [31:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'd0;
        else if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // One connection: reset, a run of good frames, polls and unused kinds, maybe a fault,
    // then a little noise.
    task automatic run_sequence();
        logic [31:0] c;
        logic [63:0] alt;
        logic [1:0]  mult;
        logic [31:0] restart;
        int unsigned r;
        int unsigned tries;
        restart   = pick_word();
        gen_stamp = $urandom;
        push_req(REQ_RESET, 1'($urandom_range(0, 1)), $urandom, gen_stamp, restart);
        gen_expect  = fold_with(restart, phase_modulus);
        gen_running = 1'b0;
        repeat ($urandom_range(2, 24))
        begin
            r = $urandom_range(0, 99);
            if (r < 62)
            begin
                // any counter that folds onto the expected value will do
                mult = 2'($urandom_range(0, 3));
                alt  = {32'd0, gen_expect} + {32'd0, phase_modulus} * {62'd0, mult};
                c    = (phase_modulus != 0 && alt <= 64'hFFFF_FFFF) ? alt[31:0] : gen_expect;
                gen_stamp = gen_stamp + safe_delta();
                push_req(REQ_FRAME, 1'b1, c, gen_stamp, $urandom);
                gen_expect  = fold_with(gen_expect + 32'd1, phase_modulus);
                gen_running = 1'b1;
            end
            else if (r < 94)
                push_req(REQ_POLL, 1'($urandom_range(0, 1)), $urandom,
                         gen_stamp + safe_delta(), $urandom);
            else
                push_req(REQ_UNUSED, 1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
        end

        r = $urandom_range(0, 99);
        if (r < 25)
            push_req(REQ_FRAME, 1'b0, $urandom_range(0, 1) ? gen_expect : $urandom,
                     $urandom, $urandom);
        else if (r < 50)
        begin
            // a counter off the sequence; a modulus of one leaves no such value
            c     = $urandom;
            tries = 0;
            while (fold_with(c, phase_modulus) == gen_expect && tries < 6)
            begin
                c = $urandom;
                tries++;
            end
            push_req(REQ_FRAME, fold_with(c, phase_modulus) != gen_expect, c, $urandom,
                     $urandom);
        end
        else if (r < 75 && phase_limit != 0 && gen_running)
            push_req(REQ_POLL, 1'($urandom_range(0, 1)), $urandom,
                     gen_stamp + $urandom_range(phase_limit, 32'hFFFF_FFFF), $urandom);

        repeat ($urandom_range(0, 4))
            push_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom,
                     $urandom, $urandom);
    endtask

    initial
    begin : stimulus
        int unsigned start;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: no modulus, 1000 ms window ----
        set_regs(32'd0, 32'd1000);
        push_req(REQ_POLL,   1'b0, 32'd0, 32'd5, 32'd0);                // poll in INIT passes
        push_req(REQ_FRAME,  1'b1, 32'd0, 32'd10, 32'd0);
        push_req(REQ_FRAME,  1'b1, 32'd1, 32'd20, 32'd0);
        push_req(REQ_POLL,   1'b1, 32'd0, 32'd1019, 32'd0);             // just inside
        push_req(REQ_POLL,   1'b1, 32'd0, 32'd1020, 32'd0);             // reaches the limit
        push_req(REQ_POLL,   1'b1, 32'd0, 32'd1021, 32'd0);             // poll in failsafe
        push_req(REQ_FRAME,  1'b1, 32'd2, 32'd1022, 32'd0);             // frame in failsafe
        push_req(REQ_UNUSED, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(REQ_RESET,  1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        push_req(REQ_FRAME,  1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'd0);  // counter wraps
        push_req(REQ_POLL,   1'b0, 32'd0, 32'h0000_0100, 32'd0);        // time wraps
        push_req(REQ_FRAME,  1'b0, 32'd0, 32'h0000_0100, 32'd0);        // bad sig, good count
        push_req(REQ_RESET,  1'b0, 32'd0, 32'd0, 32'd5);
        push_req(REQ_FRAME,  1'b1, 32'd6, 32'd1, 32'd0);                // counter fault
        push_req(REQ_RESET,  1'b0, 32'd0, 32'd0, 32'd0);
        push_req(REQ_FRAME,  1'b0, 32'd9, 32'd2, 32'd0);                // both bad: signature
        wait_results();

        // ---- directed: small modulus, widest window ----
        set_regs(32'd7, 32'hFFFF_FFFF);
        push_req(REQ_RESET, 1'b1, 32'd0, 32'h8000_0000, 32'd100);
        push_req(REQ_FRAME, 1'b1, 32'd9, 32'h8000_0000, 32'd0);
        push_req(REQ_FRAME, 1'b1, 32'hFFFF_FFFF, 32'h8000_0001, 32'd0);
        push_req(REQ_POLL,  1'b1, 32'd0, 32'h8000_0000, 32'd0);         // elapsed all ones
        wait_results();

        // ---- directed: modulus written over an unreduced expectation ----
        set_regs(32'd0, 32'd1);
        push_req(REQ_RESET, 1'b1, 32'd0, 32'd7, 32'd50);
        wait_results();
        write_reg(CFG_MODULUS, 32'd8);
        push_req(REQ_FRAME, 1'b1, 32'd50, 32'd8, 32'd0);
        wait_results();

        // ---- directed: largest modulus, one-tick window ----
        write_reg(CFG_MODULUS, 32'hFFFF_FFFF);
        push_req(REQ_RESET, 1'b0, 32'd0, 32'd3, 32'hFFFF_FFFF);
        push_req(REQ_FRAME, 1'b1, 32'hFFFF_FFFF, 32'd3, 32'd0);
        push_req(REQ_POLL,  1'b0, 32'd0, 32'd3, 32'd0);
        push_req(REQ_POLL,  1'b0, 32'd0, 32'd4, 32'd0);
        wait_results();

        // ---- random phases, each under its own register setting ----
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: set_regs(32'd0, 32'd0);
                1: set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                2: set_regs(32'd1, 32'd1);
                3: set_regs($urandom_range(2, 16), $urandom_range(50, 500));
                4: set_regs($urandom, $urandom);
                5: set_regs(32'h8000_0000, $urandom_range(1, 20));
                6: set_regs($urandom_range(2, 16), 32'd0);
                default: set_regs($urandom_range(0, 1) ? $urandom : 32'd0, 32'd1000);
            endcase
            sender_gaps_on   = (phase != 3);
            receiver_gaps_on = (phase != 3 && phase != 6);
            // block fills up behind a stalled receiver while items keep coming
            if (phase == 2)
                want_long_hold = 1'b1;
            start = items_pushed;
            while (items_pushed - start < PHASE_ITEMS)
                run_sequence();
            wait_results();
            want_long_hold = 1'b0;
        end

        wait_results();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && status_queue.size() == 0)
            $display("safety_link_sequence_watchdog verification clean");
        else
            $display("safety_link_sequence_watchdog verification failed");
        $finish;
    end

endmodule
